// ===== sv/ecsm_pkg.sv =====
package ecsm_pkg;

    localparam int FIELD_BITS  = 32;
    localparam int SCALAR_BITS = 64;
    localparam int CFG_IDX_BITS = 1;

    localparam logic [CFG_IDX_BITS-1:0] CFG_COEFF_A = 1'b0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_MODULUS = 1'b1;

    localparam logic [FIELD_BITS-1:0] COEFF_A_RESET = FIELD_BITS'(2);
    localparam logic [FIELD_BITS-1:0] MODULUS_RESET = FIELD_BITS'(97);

    typedef logic [FIELD_BITS-1:0] field_t;

    typedef struct packed {
        logic [FIELD_BITS-1:0]  point_x;
        logic [FIELD_BITS-1:0]  point_y;
        logic                   point_at_infinity;
        logic [SCALAR_BITS-1:0] scalar;
    } ecsm_in_t;

    typedef struct packed {
        logic [FIELD_BITS-1:0] result_x;
        logic [FIELD_BITS-1:0] result_y;
        logic                  result_at_infinity;
    } ecsm_out_t;

    // operands below m
    function automatic field_t addmod(input field_t a, input field_t b, input field_t m);
        logic [FIELD_BITS:0] s;
        s = {1'b0, a} + {1'b0, b};
        if (s >= {1'b0, m}) begin
            s = s - {1'b0, m};
        end
        return s[FIELD_BITS-1:0];
    endfunction

    function automatic field_t submod(input field_t a, input field_t b, input field_t m);
        field_t r;
        if (a >= b) begin
            r = a - b;
        end else begin
            r = m - (b - a);
        end
        return r;
    endfunction

endpackage

// ===== sv/ecsm_mulmod.sv =====
module ecsm_mulmod
    import ecsm_pkg::*;
(
    input  logic   aclk,
    input  logic   aresetn,
    input  logic   start,
    input  field_t op_u,
    input  field_t op_v,
    input  field_t modulus,
    output logic   done,
    output field_t product
);

    localparam int CW = $clog2(FIELD_BITS);

    logic          busy_reg;
    logic          done_reg;
    logic [CW-1:0] cnt_reg;
    field_t        acc_reg;
    field_t        u_reg;
    field_t        v_reg;
    field_t        m_reg;
    field_t        dbl;
    field_t        acc_next;

    // msb first: acc = 2*acc + bit*u, kept below m
    always_comb begin
        dbl = addmod(acc_reg, acc_reg, m_reg);
        acc_next = v_reg[FIELD_BITS-1] ? addmod(dbl, u_reg, m_reg) : dbl;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
                acc_reg  <= '0;
                u_reg    <= op_u;
                v_reg    <= op_v;
                m_reg    <= modulus;
            end else if (busy_reg) begin
                acc_reg <= acc_next;
                v_reg   <= {v_reg[FIELD_BITS-2:0], 1'b0};
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CW'(FIELD_BITS - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done    = done_reg;
    assign product = acc_reg;

endmodule

// ===== sv/ecsm_invmod.sv =====
module ecsm_invmod
    import ecsm_pkg::*;
(
    input  logic   aclk,
    input  logic   aresetn,
    input  logic   start,
    input  field_t operand,
    input  field_t modulus,
    output logic   done,
    output field_t inverse
);

    localparam int CW = $clog2(FIELD_BITS);
    localparam int TW = FIELD_BITS + 2;
    localparam int WW = 2 * FIELD_BITS + 2;

    typedef enum logic [1:0] {
        I_IDLE,
        I_RUN,
        I_FIN
    } inv_state_t;

    inv_state_t              state_reg;
    logic                    done_reg;
    field_t                  res_reg;
    field_t                  m_reg;
    field_t                  r0_reg;
    field_t                  r1_reg;
    logic [TW-1:0]           t0_reg;
    logic [TW-1:0]           t1_reg;
    logic [CW-1:0]           j_reg;

    logic [2*FIELD_BITS-1:0] r1_sh;
    logic [WW-1:0]           t1_sh;
    field_t                  r0_next;
    logic [TW-1:0]           t0_next;
    logic [TW-1:0]           m_ext;
    logic [TW-1:0]           t_pos;
    logic [TW-1:0]           t_red;

    // one quotient bit a cycle: r0 -= r1<<j, t0 -= t1<<j
    always_comb begin
        r1_sh = {{FIELD_BITS{1'b0}}, r1_reg} << j_reg;
        t1_sh = {{(WW-TW){t1_reg[TW-1]}}, t1_reg} << j_reg;
        if (r1_sh <= {{FIELD_BITS{1'b0}}, r0_reg}) begin
            r0_next = r0_reg - r1_sh[FIELD_BITS-1:0];
            t0_next = t0_reg - t1_sh[TW-1:0];
        end else begin
            r0_next = r0_reg;
            t0_next = t0_reg;
        end
        m_ext = {2'b00, m_reg};
        t_pos = t0_reg[TW-1] ? t0_reg + m_ext : t0_reg;
        t_red = (t_pos >= m_ext) ? t_pos - m_ext : t_pos;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= I_IDLE;
            done_reg  <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            case (state_reg)
                I_IDLE: begin
                    if (start) begin
                        r0_reg    <= modulus;
                        r1_reg    <= operand;
                        m_reg     <= modulus;
                        t0_reg    <= '0;
                        t1_reg    <= TW'(1);
                        j_reg     <= CW'(FIELD_BITS - 1);
                        state_reg <= I_RUN;
                    end
                end
                I_RUN: begin
                    if (r1_reg == '0) begin
                        state_reg <= I_FIN;
                    end else if (j_reg == '0) begin
                        r0_reg <= r1_reg;
                        r1_reg <= r0_next;
                        t0_reg <= t1_reg;
                        t1_reg <= t0_next;
                        j_reg  <= CW'(FIELD_BITS - 1);
                    end else begin
                        r0_reg <= r0_next;
                        t0_reg <= t0_next;
                        j_reg  <= j_reg - 1'b1;
                    end
                end
                I_FIN: begin
                    // no inverse when gcd is above one
                    res_reg   <= (r0_reg > field_t'(1)) ? '0 : t_red[FIELD_BITS-1:0];
                    done_reg  <= 1'b1;
                    state_reg <= I_IDLE;
                end
                default: begin
                    state_reg <= I_IDLE;
                end
            endcase
        end
    end

    assign done    = done_reg;
    assign inverse = res_reg;

endmodule

// ===== sv/ec_point_scalar_multiply.sv =====
// run time is data dependent: three operand reductions, then per scalar bit up to the
// highest set bit a point doubling plus a point addition when the bit is set, each three or
// four multiplies and an inverse
// one item at a time, s_ready only while idle
// reset: synchronous active-low aresetn, coeff a back to 2 and modulus to 97
module ec_point_scalar_multiply
    import ecsm_pkg::*;
(
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    s_valid,
    output logic                    s_ready,
    input  ecsm_in_t                s_data,
    output logic                    m_valid,
    input  logic                    m_ready,
    output ecsm_out_t               m_data,
    input  logic                    cfg_we,
    input  logic [CFG_IDX_BITS-1:0] cfg_index,
    input  logic [FIELD_BITS-1:0]   cfg_wdata
);

    typedef enum logic [4:0] {
        S_IDLE,
        S_RED_A,
        S_RED_X,
        S_RED_Y,
        S_BIT,
        S_DBL,
        S_SQ,
        S_TRI1,
        S_TRI2,
        S_TRI3,
        S_INV,
        S_LAM,
        S_LSQ,
        S_X2,
        S_DX,
        S_YM,
        S_NEXT,
        S_DONE
    } seq_state_t;

    seq_state_t             state_reg;
    field_t                 coeff_a_reg;
    field_t                 modulus_reg;
    field_t                 m_reg;
    field_t                 a_reg;
    field_t                 py_reg;
    logic [SCALAR_BITS-1:0] k_reg;
    field_t                 ax_reg;
    field_t                 ay_reg;
    logic                   ainf_reg;
    field_t                 bx_reg;
    field_t                 by_reg;
    logic                   binf_reg;
    field_t                 sx_reg;
    field_t                 sy_reg;
    field_t                 tx_reg;
    logic                   dst_acc_reg;
    field_t                 tmp_reg;
    field_t                 num_reg;
    field_t                 lam_reg;
    field_t                 xr_reg;
    logic                   mul_go_reg;
    field_t                 mu_reg;
    field_t                 mv_reg;
    logic                   inv_go_reg;
    field_t                 iv_reg;
    logic                   m_valid_reg;
    ecsm_out_t              m_data_reg;

    logic                   mul_done;
    field_t                 mul_res;
    logic                   inv_done;
    field_t                 inv_res;
    field_t                 one_in;
    field_t                 one_m;
    field_t                 yr;

    ecsm_mulmod u_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (mul_go_reg),
        .op_u    (mu_reg),
        .op_v    (mv_reg),
        .modulus (m_reg),
        .done    (mul_done),
        .product (mul_res)
    );

    ecsm_invmod u_inv (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (inv_go_reg),
        .operand (iv_reg),
        .modulus (m_reg),
        .done    (inv_done),
        .inverse (inv_res)
    );

    // 1 mod m, used to reduce the incoming operands through the multiplier
    assign one_in = (modulus_reg == field_t'(1)) ? '0 : field_t'(1);
    assign one_m  = (m_reg == field_t'(1)) ? '0 : field_t'(1);
    assign yr     = submod(mul_res, sy_reg, m_reg);

    assign s_ready = (state_reg == S_IDLE);
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            coeff_a_reg <= COEFF_A_RESET;
            modulus_reg <= MODULUS_RESET;
        end else if (cfg_we) begin
            case (cfg_index)
                CFG_COEFF_A: coeff_a_reg <= cfg_wdata;
                CFG_MODULUS: modulus_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            mul_go_reg  <= 1'b0;
            inv_go_reg  <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            mul_go_reg <= 1'b0;
            inv_go_reg <= 1'b0;
            if (m_valid_reg && m_ready) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE: begin
                    if (s_valid) begin
                        m_reg    <= modulus_reg;
                        k_reg    <= s_data.scalar;
                        py_reg   <= s_data.point_y;
                        binf_reg <= s_data.point_at_infinity;
                        ax_reg   <= '0;
                        ay_reg   <= '0;
                        ainf_reg <= 1'b1;
                        if (modulus_reg == '0 || s_data.scalar == '0
                            || s_data.point_at_infinity) begin
                            state_reg <= S_DONE;
                        end else begin
                            mul_go_reg <= 1'b1;
                            mu_reg     <= one_in;
                            mv_reg     <= coeff_a_reg;
                            tmp_reg    <= s_data.point_x;
                            state_reg  <= S_RED_A;
                        end
                    end
                end
                S_RED_A: begin
                    if (mul_done) begin
                        a_reg      <= mul_res;
                        mul_go_reg <= 1'b1;
                        mu_reg     <= one_m;
                        mv_reg     <= tmp_reg;
                        state_reg  <= S_RED_X;
                    end
                end
                S_RED_X: begin
                    if (mul_done) begin
                        bx_reg     <= mul_res;
                        mul_go_reg <= 1'b1;
                        mu_reg     <= one_m;
                        mv_reg     <= py_reg;
                        state_reg  <= S_RED_Y;
                    end
                end
                S_RED_Y: begin
                    if (mul_done) begin
                        by_reg    <= mul_res;
                        state_reg <= S_BIT;
                    end
                end
                S_BIT: begin
                    state_reg <= S_DBL;
                    if (k_reg[0]) begin
                        if (ainf_reg) begin
                            ax_reg   <= bx_reg;
                            ay_reg   <= by_reg;
                            ainf_reg <= binf_reg;
                        end else if (binf_reg) begin
                            ainf_reg <= 1'b0;
                        end else if (ax_reg == bx_reg
                                     && addmod(ay_reg, by_reg, m_reg) == '0) begin
                            ax_reg   <= '0;
                            ay_reg   <= '0;
                            ainf_reg <= 1'b1;
                        end else if (ax_reg == bx_reg && ay_reg == by_reg) begin
                            sx_reg      <= ax_reg;
                            sy_reg      <= ay_reg;
                            tx_reg      <= ax_reg;
                            dst_acc_reg <= 1'b1;
                            mul_go_reg  <= 1'b1;
                            mu_reg      <= ax_reg;
                            mv_reg      <= ax_reg;
                            state_reg   <= S_SQ;
                        end else begin
                            sx_reg      <= ax_reg;
                            sy_reg      <= ay_reg;
                            tx_reg      <= bx_reg;
                            dst_acc_reg <= 1'b1;
                            num_reg     <= submod(by_reg, ay_reg, m_reg);
                            inv_go_reg  <= 1'b1;
                            iv_reg      <= submod(bx_reg, ax_reg, m_reg);
                            state_reg   <= S_INV;
                        end
                    end
                end
                S_DBL: begin
                    if (binf_reg) begin
                        state_reg <= S_NEXT;
                    end else if (addmod(by_reg, by_reg, m_reg) == '0) begin
                        bx_reg    <= '0;
                        by_reg    <= '0;
                        binf_reg  <= 1'b1;
                        state_reg <= S_NEXT;
                    end else begin
                        sx_reg      <= bx_reg;
                        sy_reg      <= by_reg;
                        tx_reg      <= bx_reg;
                        dst_acc_reg <= 1'b0;
                        mul_go_reg  <= 1'b1;
                        mu_reg      <= bx_reg;
                        mv_reg      <= bx_reg;
                        state_reg   <= S_SQ;
                    end
                end
                S_SQ: begin
                    if (mul_done) begin
                        tmp_reg   <= mul_res;
                        state_reg <= S_TRI1;
                    end
                end
                S_TRI1: begin
                    num_reg   <= addmod(tmp_reg, tmp_reg, m_reg);
                    state_reg <= S_TRI2;
                end
                S_TRI2: begin
                    num_reg   <= addmod(num_reg, tmp_reg, m_reg);
                    state_reg <= S_TRI3;
                end
                S_TRI3: begin
                    // tangent slope: (3x^2 + a) / 2y
                    num_reg    <= addmod(num_reg, a_reg, m_reg);
                    inv_go_reg <= 1'b1;
                    iv_reg     <= addmod(sy_reg, sy_reg, m_reg);
                    state_reg  <= S_INV;
                end
                S_INV: begin
                    if (inv_done) begin
                        mul_go_reg <= 1'b1;
                        mu_reg     <= num_reg;
                        mv_reg     <= inv_res;
                        state_reg  <= S_LAM;
                    end
                end
                S_LAM: begin
                    if (mul_done) begin
                        lam_reg    <= mul_res;
                        mul_go_reg <= 1'b1;
                        mu_reg     <= mul_res;
                        mv_reg     <= mul_res;
                        state_reg  <= S_LSQ;
                    end
                end
                S_LSQ: begin
                    if (mul_done) begin
                        xr_reg    <= submod(mul_res, sx_reg, m_reg);
                        state_reg <= S_X2;
                    end
                end
                S_X2: begin
                    xr_reg    <= submod(xr_reg, tx_reg, m_reg);
                    state_reg <= S_DX;
                end
                S_DX: begin
                    mul_go_reg <= 1'b1;
                    mu_reg     <= lam_reg;
                    mv_reg     <= submod(sx_reg, xr_reg, m_reg);
                    state_reg  <= S_YM;
                end
                S_YM: begin
                    if (mul_done) begin
                        if (dst_acc_reg) begin
                            ax_reg    <= xr_reg;
                            ay_reg    <= yr;
                            ainf_reg  <= 1'b0;
                            state_reg <= S_DBL;
                        end else begin
                            bx_reg    <= xr_reg;
                            by_reg    <= yr;
                            binf_reg  <= 1'b0;
                            state_reg <= S_NEXT;
                        end
                    end
                end
                S_NEXT: begin
                    // nothing more can reach the accumulator once the scalar runs out
                    k_reg <= k_reg >> 1;
                    if ((k_reg >> 1) == '0) begin
                        state_reg <= S_DONE;
                    end else begin
                        state_reg <= S_BIT;
                    end
                end
                S_DONE: begin
                    if (!m_valid_reg || m_ready) begin
                        m_valid_reg                   <= 1'b1;
                        m_data_reg.result_x           <= ainf_reg ? '0 : ax_reg;
                        m_data_reg.result_y           <= ainf_reg ? '0 : ay_reg;
                        m_data_reg.result_at_infinity <= ainf_reg;
                        state_reg                     <= S_IDLE;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule
